[rtl/core/gamepad_poll_sequencer_top_defines.svh]
// Assertion macros for the game pad poll sequencer.
// Included by the top level; no other dependencies.
`ifndef GAMEPAD_POLL_SEQUENCER_TOP_DEFINES_SVH
`define GAMEPAD_POLL_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define GPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define GPS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define GPS_ASSERT(lbl, prop, msg)
`define GPS_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[rtl/core/gps_pkg.sv]
// Package for the game pad poll sequencer: phase and presence types,
// request codes, byte constants and the result record. No dependencies.
package gps_pkg;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ADDR = 3'd1,
        PH_CMD  = 3'd2,
        PH_D0   = 3'd3,
        PH_D1   = 3'd4,
        PH_D2   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        PRES_ABSENT  = 2'd0,
        PRES_PRESENT = 2'd1,
        PRES_UNKNOWN = 2'd2
    } t_presence;

    localparam logic FUNC_START     = 1'b0;
    localparam logic FUNC_BYTE_DONE = 1'b1;

    localparam logic [7:0]  TX_ADDR     = 8'h01;
    localparam logic [7:0]  TX_POLL     = 8'h42;
    localparam logic [7:0]  TX_DATA     = 8'h00;
    localparam logic [3:0]  TYPE_MIN_HI = 4'h4;
    localparam logic [15:0] BTN_NONE    = 16'hffff;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 56;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        done_res;
        logic        connected;
        logic [7:0]  pad_type;
        logic [15:0] buttons;
        logic [15:0] pressed;
        logic        presence_changed;
    } t_result;

endpackage

[rtl/core/gamepad_poll_sequencer_top.sv]
// Game pad poll sequencer: phase control, type and button capture, edge
// detection and a registered result stage. Depends on gps_pkg and the
// defines header.
//
//  Channel   Dir  tdata                                       tuser
//  s_*       in   [7:0] rx_byte, [8] ack_seen                 [0] func
//  m_*       out  [7:0] tx_byte, [8] connected, [16:9]        [0] tx_valid, [1] done_res
//                 pad_type, [32:17] buttons, [48:33] pressed,
//                 [49] presence_changed
//
// Each item is decoded against the phase register and
// its result is captured in the output register on the next edge.
// A new item is taken every cycle while the output register is empty or drained.
// A byte-done item while idle gives no result and leaves all state unchanged.
// Reset is synchronous, active low, and restores idle with unknown presence.
`include "gamepad_poll_sequencer_top_defines.svh"

module gamepad_poll_sequencer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [gps_pkg::IN_DATA_W-1:0]    i_s_tdata,   // rx_byte, ack_seen
    input  logic                             i_s_tuser,   // func
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [gps_pkg::OUT_DATA_W-1:0]   o_m_tdata,   // tx_byte, connected, pad_type,
                                                          // buttons, pressed, presence_changed
    output logic [1:0]                       o_m_tuser    // tx_valid, done_res
);
    import gps_pkg::*;

    t_phase    r_phase, n_phase;
    t_presence r_presence, n_presence;
    logic [7:0]  r_latched_type, n_latched_type;
    logic [7:0]  r_low_buttons, n_low_buttons;
    logic [15:0] r_last_buttons, n_last_buttons;
    t_result     r_result, n_result;
    logic        r_out_valid;
    logic        n_has_result;

    logic        w_func;
    logic [7:0]  w_rx;
    logic        w_ack;
    logic        w_accept;
    logic        w_finish;
    logic        w_ok;
    logic [15:0] w_btn;
    t_presence   w_now;
    logic        w_changed;
    logic [15:0] w_base;

    assign w_func   = i_s_tuser;
    assign w_rx     = i_s_tdata[7:0];
    assign w_ack    = i_s_tdata[8];
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept = i_s_tvalid && o_s_tready;

    always_comb begin
        n_phase  = r_phase;
        w_finish = 1'b0;
        w_ok     = 1'b0;
        if (w_func == FUNC_START) begin
            n_phase = PH_ADDR;
        end else begin
            unique case (r_phase)
                PH_ADDR: begin
                    n_phase  = w_ack ? PH_CMD : PH_IDLE;
                    w_finish = !w_ack;
                end
                PH_CMD: begin
                    n_phase  = w_ack ? PH_D0 : PH_IDLE;
                    w_finish = !w_ack;
                end
                PH_D0: begin
                    n_phase  = w_ack ? PH_D1 : PH_IDLE;
                    w_finish = !w_ack;
                end
                PH_D1: begin
                    n_phase  = w_ack ? PH_D2 : PH_IDLE;
                    w_finish = !w_ack;
                end
                PH_D2: begin
                    n_phase  = PH_IDLE;
                    w_finish = 1'b1;
                    w_ok     = (r_latched_type[7:4] >= TYPE_MIN_HI);
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    assign w_btn     = w_ok ? {w_rx, r_low_buttons} : BTN_NONE;
    assign w_now     = w_ok ? PRES_PRESENT : PRES_ABSENT;
    assign w_changed = (w_now != r_presence);
    assign w_base    = w_changed ? BTN_NONE : r_last_buttons;

    always_comb begin
        n_latched_type = r_latched_type;
        n_low_buttons  = r_low_buttons;
        n_last_buttons = r_last_buttons;
        n_presence     = r_presence;
        n_has_result   = 1'b1;
        n_result       = '{tx_valid: 1'b1, tx_byte: TX_DATA, done_res: 1'b0,
                           connected: 1'b0, pad_type: 8'h00, buttons: BTN_NONE,
                           pressed: 16'h0000, presence_changed: 1'b0};
        if (w_func == FUNC_START) begin
            n_result.tx_byte = TX_ADDR;
        end else if (w_finish) begin
            n_presence     = w_now;
            n_last_buttons = w_ok ? w_btn : w_base;
            n_result.tx_valid         = 1'b0;
            n_result.done_res         = 1'b1;
            n_result.connected        = w_ok;
            n_result.pad_type         = w_ok ? r_latched_type : 8'h00;
            n_result.buttons          = w_btn;
            n_result.pressed          = w_ok ? (w_base & ~w_btn) : 16'h0000;
            n_result.presence_changed = w_changed;
        end else begin
            unique case (r_phase)
                PH_ADDR: n_result.tx_byte = TX_POLL;
                PH_CMD:  n_latched_type = w_rx;
                PH_D0:   n_result.tx_byte = TX_DATA;
                PH_D1:   n_low_buttons = w_rx;
                default: n_has_result = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_presence     <= PRES_UNKNOWN;
            r_latched_type <= 8'h00;
            r_low_buttons  <= 8'h00;
            r_last_buttons <= BTN_NONE;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase        <= n_phase;
                r_presence     <= n_presence;
                r_latched_type <= n_latched_type;
                r_low_buttons  <= n_low_buttons;
                r_last_buttons <= n_last_buttons;
            end
            if (w_accept && n_has_result) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && n_has_result) begin
            r_result <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = {r_result.done_res, r_result.tx_valid};
    assign o_m_tdata  = {6'b0, r_result.presence_changed, r_result.pressed,
                         r_result.buttons, r_result.pad_type, r_result.connected,
                         r_result.tx_byte};

    `GPS_ASSERT_RST(a_rst_clears_out, !i_rst_n |=> !o_m_tvalid, "Result valid after reset.")
    `GPS_ASSERT(a_kind_onehot, o_m_tvalid |-> $onehot(o_m_tuser), "Result is not one kind.")
    `GPS_ASSERT(a_idle_no_result, (w_accept && w_func == FUNC_BYTE_DONE && r_phase == PH_IDLE && i_m_tready) |=> !o_m_tvalid, "Idle byte-done produced a result.")
    `GPS_ASSERT(a_start_sends_addr, (w_accept && w_func == FUNC_START) |=> (o_m_tvalid && o_m_tuser[0] && o_m_tdata[7:0] == TX_ADDR), "Start did not request the address byte.")

endmodule

[tb/tb_gamepad_poll_sequencer_top.sv]
// Self-checking testbench for gamepad_poll_sequencer_top: drives poll sequences
// and noise on the input stream and checks each output transfer against a predictor.
// Depends on gps_pkg and the sequencer RTL.
module tb_gamepad_poll_sequencer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gps_pkg::*;

    localparam int ITEM_TARGET   = 700;
    localparam int DRAIN_AT      = 450;
    localparam int STALL_AT      = 300;
    localparam int STALL_LEN     = 150;
    localparam int SETTLE_CYCLES = 20;
    localparam int WATCHDOG_MAX  = 2000;

    typedef struct {
        logic       func;
        logic [7:0] rx_byte;
        logic       ack_seen;
        bit         drain_first;
    } t_poll_item;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic                  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [1:0]            o_m_tuser;

    gamepad_poll_sequencer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    t_poll_item queued_requests[$];
    t_result    due_responses[$];
    t_poll_item offered;
    bit         drain_next;
    int         total_items;
    int         items_taken;
    int         stall_left;
    bit         stall_done;
    int         mismatches;
    int         quiet_cycles;

    t_phase     poll_phase;
    logic [7:0] type_latch;
    logic [7:0] btn_low;
    logic [15:0] prev_buttons;
    t_presence  pad_presence;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    function automatic t_result tx_response(input logic [7:0] tx);
        t_result r;
        r = '0;
        r.tx_valid = 1'b1;
        r.tx_byte = tx;
        r.buttons = BTN_NONE;
        return r;
    endfunction

    task automatic close_poll(input logic ok, input logic [15:0] btn);
        t_result   r;
        t_presence now;
        now = ok ? PRES_PRESENT : PRES_ABSENT;
        r = '0;
        r.done_res = 1'b1;
        r.buttons = BTN_NONE;
        if (now != pad_presence) begin
            pad_presence = now;
            prev_buttons = BTN_NONE;
            r.presence_changed = 1'b1;
        end
        if (ok) begin
            r.connected = 1'b1;
            r.pad_type = type_latch;
            r.buttons = btn;
            r.pressed = prev_buttons & ~btn;
            prev_buttons = btn;
        end
        poll_phase = PH_IDLE;
        due_responses.push_back(r);
    endtask

    task automatic advance_poll(input t_poll_item it);
        if (it.func == FUNC_START) begin
            poll_phase = PH_ADDR;
            due_responses.push_back(tx_response(TX_ADDR));
            return;
        end
        case (poll_phase)
            PH_ADDR: begin
                if (!it.ack_seen) begin
                    close_poll(1'b0, BTN_NONE);
                end else begin
                    poll_phase = PH_CMD;
                    due_responses.push_back(tx_response(TX_POLL));
                end
            end
            PH_CMD: begin
                if (!it.ack_seen) begin
                    close_poll(1'b0, BTN_NONE);
                end else begin
                    type_latch = it.rx_byte;
                    poll_phase = PH_D0;
                    due_responses.push_back(tx_response(TX_DATA));
                end
            end
            PH_D0: begin
                if (!it.ack_seen) begin
                    close_poll(1'b0, BTN_NONE);
                end else begin
                    poll_phase = PH_D1;
                    due_responses.push_back(tx_response(TX_DATA));
                end
            end
            PH_D1: begin
                if (!it.ack_seen) begin
                    close_poll(1'b0, BTN_NONE);
                end else begin
                    btn_low = it.rx_byte;
                    poll_phase = PH_D2;
                    due_responses.push_back(tx_response(TX_DATA));
                end
            end
            PH_D2: begin
                if (type_latch[7:4] < TYPE_MIN_HI) begin
                    close_poll(1'b0, BTN_NONE);
                end else begin
                    close_poll(1'b1, {it.rx_byte, btn_low});
                end
            end
            default: begin
                poll_phase = PH_IDLE;
            end
        endcase
    endtask

    task automatic add_item(input logic func, input logic [7:0] rx, input logic ack);
        t_poll_item it;
        it.func = func;
        it.rx_byte = rx;
        it.ack_seen = ack;
        it.drain_first = drain_next;
        drain_next = 1'b0;
        queued_requests.push_back(it);
    endtask

    // Bytes after the start are address, command, first data, low and high button
    // bytes; the sequence stops after the first missing acknowledge before the last.
    task automatic add_poll(input logic [7:0] typ, input logic [15:0] btn,
                            input logic [4:0] acks, input int nbytes);
        logic [7:0] rx;
        add_item(FUNC_START, 8'($urandom), 1'($urandom));
        for (int k = 0; k < nbytes; k++) begin
            case (k)
                1: rx = typ;
                3: rx = btn[7:0];
                4: rx = btn[15:8];
                default: rx = 8'($urandom);
            endcase
            add_item(FUNC_BYTE_DONE, rx, acks[k]);
            if (k < 4 && !acks[k]) begin
                break;
            end
        end
    endtask

    function automatic int idle_pct(input bit receiver);
        if (items_taken < total_items / 3) begin
            return receiver ? 77 : 35;
        end else if (items_taken < 2 * total_items / 3) begin
            return receiver ? 35 : 77;
        end
        return 0;
    endfunction

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata <= '0;
            i_s_tuser <= 1'b0;
            items_taken <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                advance_poll(offered);
                items_taken <= items_taken + 1;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (queued_requests.size() > 0
                        && !(queued_requests[0].drain_first && due_responses.size() != 0)
                        && (stall_left > 0 || $urandom_range(0, 99) >= idle_pct(1'b0))) begin
                    offered = queued_requests.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= {7'd0, offered.ack_seen, offered.rx_byte};
                    i_s_tuser <= offered.func;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left <= 0;
            stall_done <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (due_responses.size() == 0) begin
                    report_mismatch("output transfer with no response pending");
                end else begin
                    want = due_responses.pop_front();
                    check_field("tx_valid", 16'(o_m_tuser[0]), 16'(want.tx_valid));
                    check_field("tx_byte", 16'(o_m_tdata[7:0]), 16'(want.tx_byte));
                    check_field("done_res", 16'(o_m_tuser[1]), 16'(want.done_res));
                    check_field("connected", 16'(o_m_tdata[8]), 16'(want.connected));
                    check_field("pad_type", 16'(o_m_tdata[16:9]), 16'(want.pad_type));
                    check_field("buttons", o_m_tdata[32:17], want.buttons);
                    check_field("pressed", o_m_tdata[48:33], want.pressed);
                    check_field("presence_changed", 16'(o_m_tdata[49]),
                                16'(want.presence_changed));
                end
            end
            if (!stall_done && items_taken >= STALL_AT) begin
                stall_done <= 1'b1;
                stall_left <= STALL_LEN;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int         pick;
        logic [7:0] typ;
        logic [4:0] acks;

        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = 1'b0;
        i_m_tready = 1'b0;
        mismatches = 0;
        quiet_cycles = 0;
        drain_next = 1'b0;
        total_items = ITEM_TARGET;
        items_taken = 0;
        stall_left = 0;
        stall_done = 1'b0;
        poll_phase = PH_IDLE;
        type_latch = 8'h00;
        btn_low = 8'h00;
        prev_buttons = BTN_NONE;
        pad_presence = PRES_UNKNOWN;

        // Directed part: idle byte-done, missing acknowledges, type limits,
        // ignored last acknowledge, button extremes and a restart mid-poll.
        add_item(FUNC_BYTE_DONE, 8'hff, 1'b1);
        add_poll(8'h73, 16'h0000, 5'b11110, 1);
        add_poll(8'h73, 16'h0000, 5'b01111, 5);
        add_poll(8'h40, 16'hffff, 5'b11111, 5);
        add_poll(8'hff, 16'h1234, 5'b11101, 5);
        add_poll(8'hff, 16'h0000, 5'b11111, 1);
        add_poll(8'h3f, 16'h00ff, 5'b11111, 5);

        while (queued_requests.size() < ITEM_TARGET) begin
            if (!drain_next && queued_requests.size() >= DRAIN_AT
                    && queued_requests.size() < DRAIN_AT + 8) begin
                drain_next = 1'b1;
            end
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 3))
                0: typ = 8'($urandom_range(0, 8'h3f));
                1: typ = 8'($urandom);
                default: typ = 8'($urandom_range(8'h40, 8'hff));
            endcase
            if (pick < 70) begin
                add_poll(typ, 16'($urandom), {1'($urandom), 4'b1111}, 5);
            end else if (pick < 80) begin
                acks = 5'b11111;
                acks[3'($urandom_range(0, 3))] = 1'b0;
                add_poll(typ, 16'($urandom), acks, 5);
            end else if (pick < 90) begin
                add_poll(typ, 16'($urandom), 5'b11111, $urandom_range(0, 4));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    add_item(1'($urandom), 8'($urandom), 1'($urandom));
                end
            end
        end
        total_items = queued_requests.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_taken < total_items || due_responses.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (due_responses.size() != 0) begin
            report_mismatch("responses still pending at end of run");
        end
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
